// ----- rtl/rau_pkg.sv -----
// Package for the rational arithmetic unit: word width, opcodes, divider types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
	localparam int WORD_BITS = 32;
	localparam int CNT_BITS = $clog2(WORD_BITS + 1);
	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef enum logic [1:0] {
		OP_REDUCE = 2'd0,
		OP_ADD    = 2'd1,
		OP_SUB    = 2'd2,
		OP_INC    = 2'd3
	} op_t;
	typedef struct packed {
		logic start;
		word_t dividend;
		word_t divisor;
	} div_req_t;
	typedef struct packed {
		logic done;
		word_t quot;
		word_t rem;
	} div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/rau_div.sv -----
// Bit-serial signed truncating divider, one quotient bit per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rau_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire rau_pkg::div_req_t req,
	output rau_pkg::div_rsp_t rsp
);
	import rau_pkg::*;
	logic busy_q;
	logic done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [WORD_BITS-1:0] rem_q, quo_q, den_q;
	logic neg_q_q, neg_r_q;
	logic [WORD_BITS:0] trial;
	logic [WORD_BITS-1:0] rem_sh;
	logic [WORD_BITS-1:0] qv, rv;

	assign rem_sh = {rem_q[WORD_BITS-2:0], quo_q[WORD_BITS-1]};
	assign trial = {rem_q[WORD_BITS-1], rem_sh} - {1'b0, den_q};
	assign qv = neg_q_q ? -quo_q : quo_q;
	assign rv = neg_r_q ? -rem_q : rem_q;

	// Hold quotient and remainder with their signs applied once the run ends.
	assign rsp.done = done_q;
	assign rsp.quot = qv;
	assign rsp.rem = rv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_BITS'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend[WORD_BITS-1] ? -req.dividend : req.dividend;
			den_q <= req.divisor[WORD_BITS-1] ? -req.divisor : req.divisor;
			neg_q_q <= req.dividend[WORD_BITS-1] ^ req.divisor[WORD_BITS-1];
			neg_r_q <= req.dividend[WORD_BITS-1];
		end else if (busy_q) begin
			if (!trial[WORD_BITS]) begin
				rem_q <= trial[WORD_BITS-1:0];
				quo_q <= {quo_q[WORD_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit with gcd reduction.
// Depends on rau_pkg and rau_div.
//
// Usage: present kind and operands with in_valid; the item is transferred
// at a clock edge where in_valid is high and in_stall low. The unit then
// runs alone: for add and subtract the multiplier forms the products in
// states S_M1, S_M2 and S_M3, then Euclid's method runs remainder steps on
// the shared bit-serial divider (one quotient bit per cycle), then two final
// divisions make the reduced numerator and denominator. Reduce skips the
// products; increment, and a zero denominator on reduce, add or subtract,
// skip Euclid's method and the divisions and go straight to the output.
// One item is in flight at a time; in_stall is high from transfer until the
// result is loaded into the output register, so the next item can be taken
// in the cycle after the load.
// The result sits in the output register with out_valid until out_stall is
// low; the register holds while the receiver stalls, and a finished result
// waits in the sequencer with in_stall high until the register frees.
// Reset clears the sequencer and out_valid; an item in flight is dropped,
// and none is accepted during reset.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [1:0] kind,
	input  wire rau_pkg::word_t a_num,
	input  wire rau_pkg::word_t a_den,
	input  wire rau_pkg::word_t b_num,
	input  wire rau_pkg::word_t b_den,
	output logic out_valid,
	input  wire logic out_stall,
	output rau_pkg::word_t res_num,
	output rau_pkg::word_t res_den,
	output logic div_zero
);
	import rau_pkg::*;
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001, S_M1 = 9'b000000010, S_M2 = 9'b000000100,
		S_M3 = 9'b000001000, S_CHK = 9'b000010000, S_GCD = 9'b000100000,
		S_DN = 9'b001000000, S_DD = 9'b010000000, S_OUT = 9'b100000000
	} state_t;
	state_t st_q;
	logic [1:0] kind_q;
	word_t an_q, ad_q, bn_q, bd_q, n_q, d_q, ga_q, gb_q, p_q;
	// Finished result, held here until the output register is free.
	word_t rn_q, rd_q;
	logic dz_q;
	logic waiting_q;
	div_req_t dreq;
	div_rsp_t drsp;
	// Shared multiplier: one product per cycle, operands chosen by the state.
	word_t mx, my, prod;
	always_comb begin
		case (st_q)
			S_M1: begin mx = an_q; my = bd_q; end
			S_M2: begin mx = bn_q; my = ad_q; end
			default: begin mx = ad_q; my = bd_q; end
		endcase
	end
	assign prod = word_t'(mx * my);
	// The divider's quotient, with its sign already applied.
	word_t dq;
	rau_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	assign dq = drsp.quot;
	assign in_stall = (st_q != S_IDLE);
	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = ga_q;
		dreq.divisor = gb_q;
		case (st_q)
			S_GCD: dreq.start = !waiting_q && gb_q != '0;
			S_DN: begin dreq.start = !waiting_q; dreq.dividend = n_q; dreq.divisor = ga_q; end
			S_DD: begin dreq.start = !waiting_q; dreq.dividend = d_q; dreq.divisor = ga_q; end
			default: ;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid <= 1'b0;
			waiting_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (in_valid) begin
					st_q <= (kind == OP_INC || kind == OP_REDUCE) ? S_CHK : S_M1;
				end
				S_M1: st_q <= S_M2;
				S_M2: st_q <= S_M3;
				S_M3: st_q <= S_CHK;
				S_CHK: st_q <= (kind_q == OP_INC || d_q == '0) ? S_OUT : S_GCD;
				S_GCD: begin
					if (!waiting_q && gb_q == '0) st_q <= S_DN;
					else if (!waiting_q) waiting_q <= 1'b1;
					else if (drsp.done) waiting_q <= 1'b0;
				end
				S_DN, S_DD: begin
					if (!waiting_q) waiting_q <= 1'b1;
					else if (drsp.done) begin
						waiting_q <= 1'b0;
						st_q <= (st_q == S_DN) ? S_DD : S_OUT;
					end
				end
				S_OUT: if (!out_valid || !out_stall) begin
					out_valid <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
			if (out_valid && !out_stall && st_q != S_OUT) out_valid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (in_valid) begin
				kind_q <= kind; an_q <= a_num; ad_q <= a_den; bn_q <= b_num; bd_q <= b_den;
				n_q <= a_num; d_q <= a_den;
			end
			S_M1: p_q <= prod;
			S_M2: n_q <= (kind_q == OP_ADD) ? p_q + prod : p_q - prod;
			S_M3: d_q <= prod;
			S_CHK: begin
				ga_q <= n_q; gb_q <= d_q;
				if (kind_q == OP_INC) begin
					rn_q <= an_q + ad_q; rd_q <= ad_q; dz_q <= 1'b0;
				end else if (d_q == '0) begin
					rn_q <= '0; rd_q <= '0; dz_q <= 1'b1;
				end
			end
			S_GCD: if (waiting_q && drsp.done) begin
				ga_q <= gb_q; gb_q <= drsp.rem;
			end
			S_DN: if (waiting_q && drsp.done) rn_q <= dq;
			S_DD: if (waiting_q && drsp.done) begin
				rd_q <= dq; dz_q <= 1'b0;
			end
			// Load the output register only once its previous result has left.
			S_OUT: if (!out_valid || !out_stall) begin
				res_num <= rn_q; res_den <= rd_q; div_zero <= dz_q;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
